[src/assert_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SFBU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SFBU_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[src/sfbu_pkg.sv]
// Package with the shared types and constants of the speech frame bit unpacker.
`default_nettype none

package sfbu_pkg;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_DECODE = 2'd1;
  localparam logic [1:0] REQ_SETPOS = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] KIND_SILENT = 2'd0;
  localparam logic [1:0] KIND_LAR    = 2'd1;
  localparam logic [1:0] KIND_SUB    = 2'd2;

  localparam int WORD_BITS = 32;
  localparam int BUF_BITS  = 96;
  localparam int LAR_BITS  = 36;
  localparam int SUB_BITS  = 56;
  localparam int RED_STEPS = 6;
  localparam logic [1:0] LAST_SUB = 2'd3;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_HDR,
    TK_SIL,
    TK_FRM,
    TK_LAR,
    TK_SUB
  } take_e;

  typedef struct packed {
    logic       accept;
    logic       red_step;
    logic [2:0] red_shift;
    logic       mem_write;
    logic       pos_load;
    logic       flush;
    logic       fetch_en;
    take_e      take;
    logic [1:0] sub;
    logic       emit_sil;
  } cmd_t;

  typedef struct packed {
    logic take_done;
    logic hdr_bit;
    logic sil_zero;
    logic frm_zero;
  } status_t;

  function automatic logic [6:0] take_len(take_e t);
    logic [6:0] n;
    n = 7'd0;
    unique case (t)
      TK_NONE: n = 7'd0;
      TK_HDR:  n = 7'd1;
      TK_SIL:  n = 7'd4;
      TK_FRM:  n = 7'd7;
      TK_LAR:  n = 7'(LAR_BITS);
      TK_SUB:  n = 7'(SUB_BITS);
      default: n = 7'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[src/sfbu_dp.sv]
// Datapath: stream memory, bit buffer, position, run counters, modulo reducer and result registers.
`default_nettype none

module sfbu_dp #(
  parameter int STREAM_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfbu_pkg::cmd_t      cmd_i,
  output sfbu_pkg::status_t   status_o,
  input  logic [1:0]          req_type_i,
  input  logic [9:0]          word_index_i,
  input  logic [31:0]         word_data_i,
  input  logic [14:0]         bit_position_i,
  output logic                result_valid_o,
  output logic [1:0]          kind_o,
  output logic [1:0]          subframe_o,
  output logic [35:0]         lar_codes_o,
  output logic [6:0]          ltp_lag_o,
  output logic [1:0]          ltp_gain_o,
  output logic [1:0]          grid_position_o,
  output logic [5:0]          block_maximum_o,
  output logic [38:0]         pulses_o,
  output logic                last_o
);

  localparam int AW        = $clog2(STREAM_WORDS);
  localparam int RING_BITS = STREAM_WORDS * sfbu_pkg::WORD_BITS;
  localparam int PW        = $clog2(RING_BITS);
  localparam int CW        = ((PW > 15) ? PW : 15) + sfbu_pkg::RED_STEPS;
  localparam int BB        = sfbu_pkg::BUF_BITS;

  logic [31:0]    mem [STREAM_WORDS];
  logic [31:0]    data_q;
  logic [31:0]    rdata_q;
  logic           rvalid_q, rvalid_d;
  logic [14:0]    red_q, red_d;
  logic           red_ring_q, red_ring_d;
  logic [CW-1:0]  red_mod;
  logic [CW-1:0]  red_cand;
  logic [BB-1:0]  bits_q, bits_d;
  logic [6:0]     cnt_q, cnt_d;
  logic [AW-1:0]  fa_q, fa_d;
  logic [4:0]     off_q, off_d;
  logic           first_q, first_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [PW:0]    pos_sum;
  logic [4:0]     sil_q, sil_d;
  logic [7:0]     frm_q, frm_d;
  logic [6:0]     need;
  logic           take_done;
  logic [6:0]     take_n;
  logic [6:0]     rem_cnt;
  logic [BB-1:0]  shifted;
  logic [31:0]    app_data;
  logic [6:0]     app_n;
  logic [7:0]     pend;
  logic           rd_en;
  logic           emit_lar, emit_sub;

  assign need      = sfbu_pkg::take_len(cmd_i.take);
  assign take_done = (cmd_i.take != sfbu_pkg::TK_NONE) && (cnt_q >= need);
  assign take_n    = take_done ? need : 7'd0;
  assign rem_cnt   = cnt_q - take_n;
  assign shifted   = bits_q >> take_n;
  assign app_data  = first_q ? (rdata_q >> off_q) : rdata_q;
  assign app_n     = first_q ? (7'd32 - {2'b00, off_q}) : 7'd32;
  assign pend      = {1'b0, cnt_q} + (rvalid_q ? 8'd32 : 8'd0);
  assign rd_en     = cmd_i.fetch_en && !cmd_i.flush && (pend <= 8'd64);
  assign emit_lar  = take_done && (cmd_i.take == sfbu_pkg::TK_LAR);
  assign emit_sub  = take_done && (cmd_i.take == sfbu_pkg::TK_SUB);

  assign status_o.take_done = take_done;
  assign status_o.hdr_bit   = bits_q[0];
  assign status_o.sil_zero  = (sil_q == 5'd0);
  assign status_o.frm_zero  = (frm_q == 8'd0);

  assign red_mod  = red_ring_q ? CW'(RING_BITS) : CW'(STREAM_WORDS);
  assign red_cand = red_mod << cmd_i.red_shift;
  assign pos_sum  = {1'b0, pos_q} + (PW + 1)'(take_n);

  always_comb begin
    red_d      = red_q;
    red_ring_d = red_ring_q;
    if (cmd_i.accept) begin
      red_ring_d = (req_type_i == sfbu_pkg::REQ_SETPOS);
      red_d      = red_ring_d ? bit_position_i : {5'd0, word_index_i};
    end else if (cmd_i.red_step && (CW'(red_q) >= red_cand)) begin
      red_d = red_q - red_cand[14:0];
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_load) begin
      pos_d = PW'(red_q);
    end else if (take_done) begin
      pos_d = (pos_sum >= (PW + 1)'(RING_BITS)) ? PW'(pos_sum - (PW + 1)'(RING_BITS))
                                                : pos_sum[PW-1:0];
    end
  end

  always_comb begin
    bits_d   = bits_q;
    cnt_d    = cnt_q;
    fa_d     = fa_q;
    off_d    = off_q;
    first_d  = first_q;
    rvalid_d = rd_en;
    if (cmd_i.flush) begin
      bits_d   = '0;
      cnt_d    = 7'd0;
      fa_d     = AW'(pos_q >> 5);
      off_d    = pos_q[4:0];
      first_d  = 1'b1;
      rvalid_d = 1'b0;
    end else begin
      if (rvalid_q) begin
        bits_d  = shifted | (BB'(app_data) << rem_cnt);
        cnt_d   = rem_cnt + app_n;
        first_d = 1'b0;
      end else begin
        bits_d = shifted;
        cnt_d  = rem_cnt;
      end
      if (rd_en) begin
        fa_d = ({1'b0, fa_q} == (AW + 1)'(STREAM_WORDS - 1)) ? '0 : fa_q + 1'b1;
      end
    end
  end

  always_comb begin
    sil_d = sil_q;
    frm_d = frm_q;
    if (take_done && (cmd_i.take == sfbu_pkg::TK_SIL)) begin
      sil_d = {1'b0, bits_q[3:0]} + 5'd1;
    end
    if (take_done && (cmd_i.take == sfbu_pkg::TK_FRM)) begin
      frm_d = {1'b0, bits_q[6:0]} + 8'd1;
    end
    if (cmd_i.emit_sil) begin
      sil_d = sil_q - 5'd1;
    end
    if (emit_sub && (cmd_i.sub == sfbu_pkg::LAST_SUB)) begin
      frm_d = frm_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write) begin
      mem[red_q[AW-1:0]] <= data_q;
    end
    if (rd_en) begin
      rdata_q <= mem[fa_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= word_data_i;
    end
    red_q  <= red_d;
    bits_q <= bits_d;
    fa_q   <= fa_d;
    off_q  <= off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q   <= 1'b0;
      red_ring_q <= 1'b0;
      cnt_q      <= 7'd0;
      first_q    <= 1'b0;
      pos_q      <= '0;
      sil_q      <= 5'd0;
      frm_q      <= 8'd0;
    end else begin
      rvalid_q   <= rvalid_d;
      red_ring_q <= red_ring_d;
      cnt_q      <= cnt_d;
      first_q    <= first_d;
      pos_q      <= pos_d;
      sil_q      <= sil_d;
      frm_q      <= frm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= emit_lar || emit_sub || cmd_i.emit_sil;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_lar || emit_sub || cmd_i.emit_sil) begin
      kind_o          <= sfbu_pkg::KIND_SILENT;
      subframe_o      <= 2'd0;
      lar_codes_o     <= '0;
      ltp_lag_o       <= '0;
      ltp_gain_o      <= '0;
      grid_position_o <= '0;
      block_maximum_o <= '0;
      pulses_o        <= '0;
      last_o          <= 1'b1;
      if (emit_lar) begin
        kind_o      <= sfbu_pkg::KIND_LAR;
        lar_codes_o <= bits_q[35:0];
        last_o      <= 1'b0;
      end else if (emit_sub) begin
        kind_o          <= sfbu_pkg::KIND_SUB;
        subframe_o      <= cmd_i.sub;
        ltp_lag_o       <= bits_q[6:0];
        ltp_gain_o      <= bits_q[8:7];
        grid_position_o <= bits_q[10:9];
        block_maximum_o <= bits_q[16:11];
        pulses_o        <= bits_q[55:17];
        last_o          <= (cmd_i.sub == sfbu_pkg::LAST_SUB);
      end
    end
  end

endmodule

`default_nettype wire

[src/sfbu_ctrl.sv]
// Controller state machine that sequences reduction, memory writes, position loads and frame unpacking.
`default_nettype none

module sfbu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          req_type_i,
  input  sfbu_pkg::status_t   status_i,
  output sfbu_pkg::cmd_t      cmd_o,
  output logic                busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RED    = 4'd1;
  localparam logic [3:0] S_WR     = 4'd2;
  localparam logic [3:0] S_SETP   = 4'd3;
  localparam logic [3:0] S_FLUSH  = 4'd4;
  localparam logic [3:0] S_HDR    = 4'd5;
  localparam logic [3:0] S_HRUN_S = 4'd6;
  localparam logic [3:0] S_HRUN_F = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;
  localparam logic [3:0] S_LAR    = 4'd9;
  localparam logic [3:0] S_SUB    = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       is_pos_q, is_pos_d;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    is_pos_d = is_pos_q;
    cmd_o    = '0;
    cmd_o.accept    = accept;
    cmd_o.take      = sfbu_pkg::TK_NONE;
    cmd_o.red_shift = cnt_q;
    cmd_o.sub       = cnt_q[1:0];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            sfbu_pkg::REQ_WRITE: begin
              state_d  = S_RED;
              cnt_d    = 3'(sfbu_pkg::RED_STEPS - 1);
              is_pos_d = 1'b0;
            end
            sfbu_pkg::REQ_SETPOS: begin
              state_d  = S_RED;
              cnt_d    = 3'(sfbu_pkg::RED_STEPS - 1);
              is_pos_d = 1'b1;
            end
            sfbu_pkg::REQ_DECODE: state_d = S_FLUSH;
            sfbu_pkg::REQ_UNUSED: state_d = S_IDLE;
            default:              state_d = S_IDLE;
          endcase
        end
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        if (cnt_q == 3'd0) begin
          state_d = is_pos_q ? S_SETP : S_WR;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      S_WR: begin
        cmd_o.mem_write = 1'b1;
        state_d = S_IDLE;
      end
      S_SETP: begin
        cmd_o.pos_load = 1'b1;
        state_d = S_IDLE;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d = (status_i.sil_zero && status_i.frm_zero) ? S_HDR : S_CHK;
      end
      S_HDR: begin
        cmd_o.fetch_en = 1'b1;
        cmd_o.take     = sfbu_pkg::TK_HDR;
        if (status_i.take_done) begin
          state_d = status_i.hdr_bit ? S_HRUN_S : S_HRUN_F;
        end
      end
      S_HRUN_S: begin
        cmd_o.fetch_en = 1'b1;
        cmd_o.take     = sfbu_pkg::TK_SIL;
        if (status_i.take_done) begin
          state_d = S_CHK;
        end
      end
      S_HRUN_F: begin
        cmd_o.fetch_en = 1'b1;
        cmd_o.take     = sfbu_pkg::TK_FRM;
        if (status_i.take_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.fetch_en = 1'b1;
        if (!status_i.sil_zero) begin
          cmd_o.emit_sil = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_LAR;
        end
      end
      S_LAR: begin
        cmd_o.fetch_en = 1'b1;
        cmd_o.take     = sfbu_pkg::TK_LAR;
        if (status_i.take_done) begin
          state_d = S_SUB;
          cnt_d   = 3'd0;
        end
      end
      S_SUB: begin
        cmd_o.fetch_en = 1'b1;
        cmd_o.take     = sfbu_pkg::TK_SUB;
        if (status_i.take_done) begin
          if (cnt_q[1:0] == sfbu_pkg::LAST_SUB) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= 3'd0;
      is_pos_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      is_pos_q <= is_pos_d;
    end
  end

endmodule

`default_nettype wire

[src/speech_frame_bit_unpacker.sv]
// Word writes and position sets occupy the block for 6 modulo steps after acceptance, then a
// memory write or position load. A decode with silence pending gives its one result from the
// check state; when a run header is read first, the header bit and run length come before it.
// Word reads into the 96-bit bit buffer pause while more than 64 bits are held or in flight.
// Results are registered in the cycle after their bits are taken. The receiver cannot stall.
// Reset clears the read position, both run counters, the buffer fill and the controller state.
`default_nettype none

module speech_frame_bit_unpacker #(
  parameter int STREAM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  word_index_i,
  input  logic [31:0] word_data_i,
  input  logic [14:0] bit_position_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [1:0]  subframe_o,
  output logic [35:0] lar_codes_o,
  output logic [6:0]  ltp_lag_o,
  output logic [1:0]  ltp_gain_o,
  output logic [1:0]  grid_position_o,
  output logic [5:0]  block_maximum_o,
  output logic [38:0] pulses_o,
  output logic        last_o
);

  sfbu_pkg::cmd_t    cmd;
  sfbu_pkg::status_t status;

  sfbu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  sfbu_dp #(
    .STREAM_WORDS (STREAM_WORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_type_i),
    .word_index_i    (word_index_i),
    .word_data_i     (word_data_i),
    .bit_position_i  (bit_position_i),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .subframe_o      (subframe_o),
    .lar_codes_o     (lar_codes_o),
    .ltp_lag_o       (ltp_lag_o),
    .ltp_gain_o      (ltp_gain_o),
    .grid_position_o (grid_position_o),
    .block_maximum_o (block_maximum_o),
    .pulses_o        (pulses_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

[src/sfbu_checker.sv]
// Port-level checker for the speech frame bit unpacker and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module sfbu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  req_type_i,
  input logic [9:0]  word_index_i,
  input logic [31:0] word_data_i,
  input logic [14:0] bit_position_i,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [1:0]  subframe_o,
  input logic [35:0] lar_codes_o,
  input logic [6:0]  ltp_lag_o,
  input logic [1:0]  ltp_gain_o,
  input logic [1:0]  grid_position_o,
  input logic [5:0]  block_maximum_o,
  input logic [38:0] pulses_o,
  input logic        last_o
);

  `SFBU_ASSERT(a_req_goes_busy, clk_i, rst_ni, start && !busy && (req_type_i != sfbu_pkg::REQ_UNUSED) |=> busy, "accepted transaction did not raise busy")
  `SFBU_ASSERT(a_result_from_busy, clk_i, rst_ni, result_valid_o |-> $past(busy), "result strobe without a decode in progress")
  `SFBU_ASSERT(a_silent_is_last, clk_i, rst_ni, result_valid_o && (kind_o == sfbu_pkg::KIND_SILENT) |-> last_o && (lar_codes_o == '0) && (pulses_o == '0), "silent result is not a clean final result")
  `SFBU_NEVER(a_lar_not_last, clk_i, rst_ni, result_valid_o && (kind_o == sfbu_pkg::KIND_LAR) && (last_o || (subframe_o != 2'd0)), "LAR result marked last or with a subframe number")
  `SFBU_ASSERT(a_sub_follows, clk_i, rst_ni, result_valid_o && (kind_o == sfbu_pkg::KIND_SUB) && !last_o |=> busy || result_valid_o, "frame ended before its final subframe")

endmodule

bind speech_frame_bit_unpacker sfbu_checker u_sfbu_checker (.*);

`default_nettype wire
